/* src/fvc_pkg.sv */
// ----------------------------------------------------------------------------
// fvc_pkg
// Shared types and constants of the frustum volume classifier: plane
// packing, accumulator width, verdict codes and the structs that travel
// along the chain of plane cells.
// ----------------------------------------------------------------------------
package fvc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int PLANE_W    = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int COORD_W    = 16;
    localparam int EXT_W      = 15;
    localparam int Q_SHIFT    = 14;
    // worst case |d| + |r| stays below 2^34, the top bit is the sign
    localparam int ACC_W      = 35;
    // two register stages per cell plus the output register
    localparam int PIPE_LAT   = 2 * NUM_PLANES + 1;

    localparam logic [1:0] VERDICT_OUTSIDE    = 2'd0;
    localparam logic [1:0] VERDICT_INTERSECTS = 2'd1;
    localparam logic [1:0] VERDICT_INSIDE     = 2'd2;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [EXT_W-1:0]          half_x;
        logic [EXT_W-1:0]          half_y;
        logic [EXT_W-1:0]          half_z;
        logic [EXT_W-1:0]          radius;
    } t_item;

    typedef struct packed {
        logic valid;
        logic outside;
        logic all_in;
    } t_flags;

endpackage

/* src/fvc_cell.sv */
// ----------------------------------------------------------------------------
// fvc_cell
// One plane of the frustum. Holds its plane register, tests the passing
// volume against it in two stages (products, then sums and compares) and
// hands the volume and the running verdict flags to the next cell.
// ----------------------------------------------------------------------------
module fvc_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fvc_pkg::PLANE_W-1:0]   i_cfg_data,
    input  fvc_pkg::t_flags               i_flags,
    input  fvc_pkg::t_item                i_item,
    output fvc_pkg::t_flags               o_flags,
    output fvc_pkg::t_item                o_item
);
    import fvc_pkg::*;

    // magnitude of a q1.14 component; -2.0 gives 0x8000 exactly
    function automatic logic [COORD_W-1:0] mag16(input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W:0] ext;
        logic signed [COORD_W:0] neg;
        ext = {v[COORD_W-1], v};
        neg = -ext;
        mag16 = v[COORD_W-1] ? neg[COORD_W-1:0] : v;
    endfunction

    logic [PLANE_W-1:0] r_plane;

    logic signed [COORD_W-1:0] nx, ny, nz, off;
    assign nx  = $signed(r_plane[63:48]);
    assign ny  = $signed(r_plane[47:32]);
    assign nz  = $signed(r_plane[31:16]);
    assign off = $signed(r_plane[15:0]);

    // stage 1: products
    t_flags r_s1_flags;
    t_item  r_s1_item;
    logic signed [2*COORD_W-1:0]     r_px, r_py, r_pz, n_px, n_py, n_pz;
    logic [COORD_W+EXT_W-1:0]        r_ax, r_ay, r_az, n_ax, n_ay, n_az;

    always_comb begin
        n_px = nx * $signed(i_item.center_x);
        n_py = ny * $signed(i_item.center_y);
        n_pz = nz * $signed(i_item.center_z);
        n_ax = mag16(nx) * i_item.half_x;
        n_ay = mag16(ny) * i_item.half_y;
        n_az = mag16(nz) * i_item.half_z;
    end

    // stage 2: distance, projected radius, compares
    t_flags r_s2_flags, n_s2_flags;
    t_item  r_s2_item;
    logic signed [ACC_W-1:0] d_sum, rproj, lo_sum, hi_sum;

    always_comb begin
        d_sum = ACC_W'(r_px) + ACC_W'(r_py) + ACC_W'(r_pz)
              + (ACC_W'(off) <<< Q_SHIFT);
        if (r_s1_item.kind) begin
            rproj = ACC_W'({r_s1_item.radius, {Q_SHIFT{1'b0}}});
        end else begin
            rproj = ACC_W'(r_ax) + ACC_W'(r_ay) + ACC_W'(r_az);
        end
        hi_sum = d_sum + rproj;
        lo_sum = d_sum - rproj;
        n_s2_flags.valid   = r_s1_flags.valid;
        n_s2_flags.outside = r_s1_flags.outside | hi_sum[ACC_W-1];
        n_s2_flags.all_in  = r_s1_flags.all_in & ~lo_sum[ACC_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane    <= '0;
            r_s1_flags <= '0;
            r_s2_flags <= '0;
        end else begin
            if (i_cfg_we) begin
                r_plane <= i_cfg_data;
            end
            r_s1_flags <= i_flags;
            r_s2_flags <= n_s2_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_item <= i_item;
        r_px      <= n_px;
        r_py      <= n_py;
        r_pz      <= n_pz;
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_az      <= n_az;
        r_s2_item <= r_s1_item;
    end

    assign o_flags = r_s2_flags;
    assign o_item  = r_s2_item;

endmodule

/* src/frustum_volume_classifier_top.sv */
// ----------------------------------------------------------------------------
// frustum_volume_classifier_top
// Classifies boxes and spheres against six frustum planes.
// ----------------------------------------------------------------------------
// usage:
//   - write the six planes through i_cfg_we / i_cfg_index / i_cfg_data while
//     no transaction is in flight; index 0..5 is near, far, left, right, top,
//     bottom; other indexes are ignored
//   - raise i_start with a volume on the payload ports; o_busy stays low, so
//     a transaction is taken on every cycle that i_start is high
//   - the verdict appears on o_verdict with o_valid high for one cycle, after
//     two register stages in each of the six plane cells and then the output
//     register; the first stage loads at the accepting edge
//   - throughput is one volume per cycle; the cells form a shift chain, each
//     tests its own plane while the volume moves on to the next
//   - results cannot be held off; each must be taken in its strobe cycle
//   - reset clears all planes to zero (boxes and zero-radius spheres then read
//     inside, larger spheres intersect) and drops every transaction in flight
// ----------------------------------------------------------------------------
module frustum_volume_classifier_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fvc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fvc_pkg::PLANE_W-1:0]          i_cfg_data,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic                                 i_kind,
    input  logic signed [fvc_pkg::COORD_W-1:0]   i_center_x,
    input  logic signed [fvc_pkg::COORD_W-1:0]   i_center_y,
    input  logic signed [fvc_pkg::COORD_W-1:0]   i_center_z,
    input  logic [fvc_pkg::EXT_W-1:0]            i_half_x,
    input  logic [fvc_pkg::EXT_W-1:0]            i_half_y,
    input  logic [fvc_pkg::EXT_W-1:0]            i_half_z,
    input  logic [fvc_pkg::EXT_W-1:0]            i_radius,
    output logic                                 o_valid,
    output logic [1:0]                           o_verdict
);
    import fvc_pkg::*;

    t_flags chain_flags [NUM_PLANES+1];
    t_item  chain_item  [NUM_PLANES+1];

    logic       r_out_valid;
    logic [1:0] r_verdict, n_verdict;

    // the chain never stalls
    assign o_busy = 1'b0;

    assign chain_flags[0].valid   = i_start;
    assign chain_flags[0].outside = 1'b0;
    assign chain_flags[0].all_in  = 1'b1;

    assign chain_item[0].kind     = i_kind;
    assign chain_item[0].center_x = i_center_x;
    assign chain_item[0].center_y = i_center_y;
    assign chain_item[0].center_z = i_center_z;
    assign chain_item[0].half_x   = i_half_x;
    assign chain_item[0].half_y   = i_half_y;
    assign chain_item[0].half_z   = i_half_z;
    assign chain_item[0].radius   = i_radius;

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
        fvc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cfg_we   (i_cfg_we && (i_cfg_index == CFG_IDX_W'(g))),
            .i_cfg_data (i_cfg_data),
            .i_flags    (chain_flags[g]),
            .i_item     (chain_item[g]),
            .o_flags    (chain_flags[g+1]),
            .o_item     (chain_item[g+1])
        );
    end

    always_comb begin
        if (chain_flags[NUM_PLANES].outside) begin
            n_verdict = VERDICT_OUTSIDE;
        end else if (chain_flags[NUM_PLANES].all_in) begin
            n_verdict = VERDICT_INSIDE;
        end else begin
            n_verdict = VERDICT_INTERSECTS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= chain_flags[NUM_PLANES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_verdict;

`ifndef ASSERT_OFF
    // every accepted transaction produces its strobe once through the cells and the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(PIPE_LAT) o_valid)
        else $error("result strobe missing after accepted transaction");

    // no strobe without a transaction accepted at the matching edge
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_rst_n, PIPE_LAT)) |-> $past(i_start && !o_busy, PIPE_LAT))
        else $error("result strobe without accepted transaction");

    // the verdict is always one of the three legal codes
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_verdict == VERDICT_OUTSIDE || o_verdict == VERDICT_INTERSECTS
                     || o_verdict == VERDICT_INSIDE))
        else $error("illegal verdict code");
`endif

endmodule

/* tb/frustum_volume_classifier_top_tb.sv */
// ----------------------------------------------------------------------------
// frustum_volume_classifier_top_tb
// Self-checking bench for the frustum volume classifier. It loads plane sets
// over the config port and streams boxes and spheres through the command
// handshake, with random gaps between transactions. A shadow copy of the
// planes feeds an exact plane-distance predictor. Each verdict strobe is
// checked against the oldest predicted verdict.
// ----------------------------------------------------------------------------
module frustum_volume_classifier_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fvc_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int STALL_LIMIT     = 1000;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 85;

    localparam int IDX_NEAR   = 0;
    localparam int IDX_FAR    = 1;
    localparam int IDX_LEFT   = 2;
    localparam int IDX_RIGHT  = 3;
    localparam int IDX_TOP    = 4;
    localparam int IDX_BOTTOM = 5;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    localparam logic [15:0] Q_ONE     = 16'h4000;
    localparam logic [15:0] Q_NEG_ONE = 16'hC000;
    localparam logic [15:0] Q_NEG_TWO = 16'h8000;
    localparam logic [15:0] Q_MAX     = 16'h7FFF;

    typedef logic [PLANE_W-1:0] t_plane_set [NUM_PLANES];

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [PLANE_W-1:0]        i_cfg_data  = '0;
    logic                      i_start     = 1'b0;
    logic                      i_kind      = 1'b0;
    logic signed [COORD_W-1:0] i_center_x  = '0;
    logic signed [COORD_W-1:0] i_center_y  = '0;
    logic signed [COORD_W-1:0] i_center_z  = '0;
    logic [EXT_W-1:0]          i_half_x    = '0;
    logic [EXT_W-1:0]          i_half_y    = '0;
    logic [EXT_W-1:0]          i_half_z    = '0;
    logic [EXT_W-1:0]          i_radius    = '0;
    logic                      o_busy;
    logic                      o_valid;
    logic [1:0]                o_verdict;

    t_plane_set   plane_shadow = '{default: '0};
    logic [1:0]   pending_verdicts[$];
    int           mismatches   = 0;
    int           idle_pct     = 0;
    int           stall_cycles = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    frustum_volume_classifier_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_kind      (i_kind),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_center_z  (i_center_z),
        .i_half_x    (i_half_x),
        .i_half_y    (i_half_y),
        .i_half_z    (i_half_z),
        .i_radius    (i_radius),
        .o_valid     (o_valid),
        .o_verdict   (o_verdict)
    );

    // exact Q.14 plane test of one volume against the shadow planes
    function automatic logic [1:0] classify_volume(t_item v);
        logic signed [15:0] nx16, ny16, nz16, off16;
        logic signed [COORD_W-1:0] cx16, cy16, cz16;
        longint nx, ny, nz, d_sum, proj;
        bit outside, all_in;
        int i;
        outside = 1'b0;
        all_in  = 1'b1;
        cx16 = v.center_x;
        cy16 = v.center_y;
        cz16 = v.center_z;
        for (i = 0; i < NUM_PLANES; i++) begin
            {nx16, ny16, nz16, off16} = plane_shadow[i];
            nx = longint'(nx16);
            ny = longint'(ny16);
            nz = longint'(nz16);
            d_sum = nx * longint'(cx16) + ny * longint'(cy16) + nz * longint'(cz16)
                  + longint'(off16) * (longint'(1) << Q_SHIFT);
            if (v.kind)
                proj = longint'(v.radius) * (longint'(1) << Q_SHIFT);
            else
                proj = (nx < 0 ? -nx : nx) * longint'(v.half_x)
                     + (ny < 0 ? -ny : ny) * longint'(v.half_y)
                     + (nz < 0 ? -nz : nz) * longint'(v.half_z);
            if (d_sum + proj < 0)
                outside = 1'b1;
            if (d_sum - proj < 0)
                all_in = 1'b0;
        end
        if (outside)
            return VERDICT_OUTSIDE;
        else if (all_in)
            return VERDICT_INSIDE;
        return VERDICT_INTERSECTS;
    endfunction

    function automatic t_item make_volume(bit kind, int cx, int cy, int cz,
                                          int hx, int hy, int hz, int rad);
        t_item v;
        v.kind     = kind;
        v.center_x = 16'(cx);
        v.center_y = 16'(cy);
        v.center_z = 16'(cz);
        v.half_x   = 15'(hx);
        v.half_y   = 15'(hy);
        v.half_z   = 15'(hz);
        v.radius   = 15'(rad);
        return v;
    endfunction

    // mix of full-range and near-origin volumes
    function automatic t_item random_volume();
        t_item v;
        int sh;
        sh = $urandom_range(3) * 4;
        v.kind     = 1'($urandom_range(1));
        v.center_x = $signed(16'($urandom)) >>> sh;
        v.center_y = $signed(16'($urandom)) >>> sh;
        v.center_z = $signed(16'($urandom)) >>> sh;
        sh = $urandom_range(3) * 4;
        v.half_x   = 15'($urandom) >> sh;
        v.half_y   = 15'($urandom) >> sh;
        v.half_z   = 15'($urandom) >> sh;
        v.radius   = 15'($urandom) >> sh;
        return v;
    endfunction

    function automatic logic [PLANE_W-1:0] random_plane(bit origin_in);
        logic [PLANE_W-1:0] p;
        int k;
        p = {$urandom, $urandom};
        // now and then pin a normal component to full scale
        for (k = 1; k < 4; k++) begin
            case ($urandom_range(15))
                0: p[k*16 +: 16] = Q_NEG_TWO;
                1: p[k*16 +: 16] = Q_MAX;
                default: ;
            endcase
        end
        // a non-negative offset keeps the origin on the inner side
        if (origin_in)
            p[15] = 1'b0;
        return p;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    task automatic send_volume(input t_item v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_kind     <= v.kind;
        i_center_x <= v.center_x;
        i_center_y <= v.center_y;
        i_center_z <= v.center_z;
        i_half_x   <= v.half_x;
        i_half_y   <= v.half_y;
        i_half_z   <= v.half_z;
        i_radius   <= v.radius;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        pending_verdicts.push_back(classify_volume(v));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PLANE_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx < NUM_PLANES)
            plane_shadow[idx] = data;
    endtask

    // planes change only with the pipeline drained
    task automatic load_frustum(input t_plane_set planes, input bit spare_writes);
        int i;
        i_start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
        for (i = 0; i < NUM_PLANES; i++)
            write_reg(CFG_IDX_W'(i), planes[i]);
        if (spare_writes) begin
            write_reg(IDX_SPARE_LO, '1);
            write_reg(IDX_SPARE_HI, {$urandom, $urandom});
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [PLANE_W-1:0] pack_plane(logic [15:0] nx, logic [15:0] ny,
                                                      logic [15:0] nz, int off);
        return {nx, ny, nz, 16'(off)};
    endfunction

    task automatic test_reset_planes();
        idle_pct = 30;
        send_volume(make_volume(0, 32767, -32768, 0, 32767, 0, 32767, 0));
        send_volume(make_volume(1, -32768, 32767, -1, 0, 32767, 0, 32767));
        send_volume(make_volume(0, 0, 0, 0, 0, 0, 0, 0));
        send_volume(make_volume(1, 1, -1, 32767, 21845, 10922, 21845, 0));
    endtask

    // cube of half size 1000 around the origin, volumes touching its faces
    task automatic test_box_frustum();
        t_plane_set set;
        set[IDX_NEAR]   = pack_plane(0, 0, Q_ONE, 1000);
        set[IDX_FAR]    = pack_plane(0, 0, Q_NEG_ONE, 1000);
        set[IDX_LEFT]   = pack_plane(Q_ONE, 0, 0, 1000);
        set[IDX_RIGHT]  = pack_plane(Q_NEG_ONE, 0, 0, 1000);
        set[IDX_TOP]    = pack_plane(0, Q_NEG_ONE, 0, 1000);
        set[IDX_BOTTOM] = pack_plane(0, Q_ONE, 0, 1000);
        load_frustum(set, 1'b0);
        idle_pct = 30;
        send_volume(make_volume(1, 0, 0, 0, 0, 0, 0, 0));
        send_volume(make_volume(1, 0, 0, 0, 0, 0, 0, 1000));
        send_volume(make_volume(1, -2000, 0, 0, 0, 0, 0, 1000));
        send_volume(make_volume(1, -2001, 0, 0, 0, 0, 0, 1000));
        send_volume(make_volume(0, 500, 0, 0, 500, 500, 500, 0));
        send_volume(make_volume(0, 1500, 0, 0, 500, 500, 500, 0));
        send_volume(make_volume(0, 1501, 0, 0, 500, 500, 500, 0));
        send_volume(make_volume(0, 0, 0, 0, 32767, 32767, 32767, 7));
    endtask

    // left plane with normal -2.0, whose magnitude must be 2.0
    task automatic test_negative_normal();
        t_plane_set set;
        set = plane_shadow;
        set[IDX_LEFT] = pack_plane(Q_NEG_TWO, 0, 0, 2000);
        load_frustum(set, 1'b0);
        send_volume(make_volume(0, 1250, 0, 0, 250, 0, 0, 0));
        send_volume(make_volume(0, 1251, 0, 0, 250, 0, 0, 0));
        send_volume(make_volume(0, 750, 0, 0, 250, 0, 0, 0));
        send_volume(make_volume(1, 500, 0, 0, 0, 0, 0, 600));
    endtask

    task automatic test_extreme_planes();
        t_plane_set set;
        set = '{default: {4{Q_NEG_TWO}}};
        load_frustum(set, 1'b1);
        idle_pct = 0;
        send_volume(make_volume(0, 32767, 32767, 32767, 32767, 32767, 32767, 0));
        send_volume(make_volume(0, -32768, -32768, -32768, 0, 0, 0, 32767));
        send_volume(make_volume(1, 0, 0, 0, 0, 0, 0, 32767));
        send_volume(make_volume(1, 32767, -32768, 32767, 32767, 0, 32767, 0));
        set = '{default: {4{Q_MAX}}};
        load_frustum(set, 1'b1);
        send_volume(make_volume(0, -32768, -32768, -32768, 32767, 32767, 32767, 0));
        send_volume(make_volume(1, -32768, 32767, -32768, 0, 0, 0, 32767));
        set = '{default: '1};
        load_frustum(set, 1'b0);
        send_volume(make_volume(0, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_volume(make_volume(1, -32768, -32768, -32768, 0, 0, 0, 1));
        set = '{default: '0};
        load_frustum(set, 1'b0);
        send_volume(make_volume(0, -32768, 32767, 0, 32767, 32767, 32767, 32767));
    endtask

    task automatic test_random_volumes();
        t_plane_set set;
        int ph, i;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (i = 0; i < NUM_PLANES; i++)
                set[i] = random_plane(ph % 4 != 3);
            load_frustum(set, ph % 5 == 2);
            idle_pct = (ph % 3 == 0) ? 0 : 35;
            repeat (ITEMS_PER_PHASE) send_volume(random_volume());
        end
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : check_verdicts
        logic [1:0] want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (pending_verdicts.size() == 0) begin
                note_failure($sformatf("verdict %0d with no transaction pending", o_verdict));
            end else begin
                want = pending_verdicts.pop_front();
                if (o_valid !== 1'b1 || o_verdict !== want)
                    note_failure($sformatf("verdict mismatch: expected %0d, got %0d (valid %b)",
                                           want, o_verdict, o_valid));
            end
        end
    end

    // ends the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || o_valid === 1'b1 || (i_start && o_busy === 1'b0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d verdicts pending", pending_verdicts.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_planes();
        test_box_frustum();
        test_negative_normal();
        test_extreme_planes();
        test_random_volumes();
        i_start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
src/fvc_pkg.sv
src/fvc_cell.sv
src/frustum_volume_classifier_top.sv
tb/frustum_volume_classifier_top_tb.sv
